FILE: rtl/core/rar_pkg.sv
`default_nettype none

package rar_pkg;

  // default operand width and queue depth between front and back
  localparam int unsigned RAR_OPERAND_WIDTH = 16;
  localparam int unsigned RAR_QUEUE_DEPTH   = 2;

  // operation codes; the last one passes a through (reduced)
  typedef enum logic [1:0] {
    RAR_ADD  = 2'd0,
    RAR_MUL  = 2'd1,
    RAR_DIV  = 2'd2,
    RAR_PASS = 2'd3
  } rar_func_e;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } rar_q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/rar_front.sv
`default_nettype none

module rar_front
  import rar_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = RAR_OPERAND_WIDTH,
  localparam int unsigned PW = 2 * OPERAND_WIDTH,
  localparam int unsigned EW = 3 * PW
) (
  input  wire logic                            start,
  input  wire rar_q_stat_t                     q_stat_i,
  input  wire logic        [1:0]               func_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_den_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_den_i,
  output logic                                 push_o,
  output logic             [EW-1:0]            push_data_o
);

  localparam logic signed [OPERAND_WIDTH-1:0] One = OPERAND_WIDTH'(1);

  rar_func_e                       func;
  logic signed [OPERAND_WIDTH-1:0] m0_b;
  logic signed [OPERAND_WIDTH-1:0] m2_b;
  logic signed [PW-1:0]            m0;
  logic signed [PW-1:0]            m1;
  logic signed [PW-1:0]            m2;

  assign func = rar_func_e'(func_i);

  // pick the second factor of each product from the operation
  always_comb begin
    case (func)
      RAR_ADD: begin
        m0_b = b_den_i;
        m2_b = b_den_i;
      end
      RAR_MUL: begin
        m0_b = b_num_i;
        m2_b = b_den_i;
      end
      RAR_DIV: begin
        m0_b = b_den_i;
        m2_b = b_num_i;
      end
      default: begin
        m0_b = One;
        m2_b = One;
      end
    endcase
  end

  // numerator terms and denominator; factors sign-extended to full width
  assign m0 = PW'(a_num_i) * PW'(m0_b);
  assign m1 = (func == RAR_ADD) ? (PW'(b_num_i) * PW'(a_den_i)) : '0;
  assign m2 = PW'(a_den_i) * PW'(m2_b);

  assign push_o      = start && !q_stat_i.full;
  assign push_data_o = {m0, m1, m2};

endmodule

`default_nettype wire

FILE: rtl/core/rar_queue.sv
`default_nettype none

module rar_queue
  import rar_pkg::*;
#(
  parameter int unsigned WIDTH = 6 * RAR_OPERAND_WIDTH,
  parameter int unsigned DEPTH = RAR_QUEUE_DEPTH,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [WIDTH-1:0]  push_data_i,
  input  wire logic              pop_i,
  output logic      [WIDTH-1:0]  pop_data_o,
  output rar_q_stat_t            stat_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + CW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: rtl/core/rar_back.sv
`default_nettype none

module rar_back
  import rar_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = RAR_OPERAND_WIDTH,
  localparam int unsigned PW = 2 * OPERAND_WIDTH,
  localparam int unsigned EW = 3 * PW,
  localparam int unsigned RW = PW + 1,
  localparam int unsigned MW = PW,
  localparam int unsigned KW = $clog2(MW + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rar_q_stat_t         q_stat_i,
  input  wire logic       [EW-1:0] pop_data_i,
  output logic                     pop_o,
  output logic                     valid_o,
  output logic signed     [RW-1:0] res_num_o,
  output logic signed     [RW-1:0] res_den_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_GCD,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e               state_q;
  logic signed [RW-1:0] n_q, d_q;
  logic                 sn_q, sd_q;
  logic        [MW-1:0] u_q, v_q;
  logic        [KW-1:0] k_q, cnt_q;
  logic        [MW-1:0] g_q;
  logic        [MW-1:0] ra_q, rb_q, qa_q, qb_q;
  logic                 valid_q;
  logic signed [RW-1:0] res_num_q, res_den_q;

  logic signed [PW-1:0] m0, m1, m2;
  logic signed [RW-1:0] sum, neg_n, neg_d;
  logic        [MW-1:0] mag_n, mag_d;
  logic        [MW-1:0] u_d, v_d, u_m_v, v_m_u;
  logic        [KW-1:0] k_d;
  logic        [MW:0]   ta, tb;
  logic                 ga, gb;
  logic signed [RW-1:0] qa_ext, qb_ext;

  assign m0    = signed'(pop_data_i[EW-1 -: PW]);
  assign m1    = signed'(pop_data_i[PW +: PW]);
  assign m2    = signed'(pop_data_i[PW-1:0]);
  assign sum   = RW'(m0) + RW'(m1);
  assign pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;

  // magnitudes always fit in MW bits
  assign neg_n = -n_q;
  assign neg_d = -d_q;
  assign mag_n = n_q[RW-1] ? neg_n[MW-1:0] : n_q[MW-1:0];
  assign mag_d = d_q[RW-1] ? neg_d[MW-1:0] : d_q[MW-1:0];

  // one binary gcd step
  assign u_m_v = u_q - v_q;
  assign v_m_u = v_q - u_q;
  always_comb begin
    u_d = u_q;
    v_d = v_q;
    k_d = k_q;
    if (!u_q[0] && !v_q[0]) begin
      u_d = u_q >> 1;
      v_d = v_q >> 1;
      k_d = k_q + KW'(1);
    end else if (!u_q[0]) begin
      u_d = u_q >> 1;
    end else if (!v_q[0]) begin
      v_d = v_q >> 1;
    end else if (u_q >= v_q) begin
      u_d = u_m_v >> 1;
    end else begin
      v_d = v_m_u >> 1;
    end
  end

  // restoring division step, numerator and denominator side by side
  assign ta = {ra_q, qa_q[MW-1]};
  assign tb = {rb_q, qb_q[MW-1]};
  assign ga = (ta >= {1'b0, g_q});
  assign gb = (tb >= {1'b0, g_q});

  assign qa_ext = sn_q ? -RW'({1'b0, qa_q}) : RW'({1'b0, qa_q});
  assign qb_ext = sd_q ? -RW'({1'b0, qb_q}) : RW'({1'b0, qb_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= 1'b0;
      n_q       <= '0;
      d_q       <= '0;
      sn_q      <= 1'b0;
      sd_q      <= 1'b0;
      u_q       <= '0;
      v_q       <= '0;
      k_q       <= '0;
      cnt_q     <= '0;
      g_q       <= '0;
      ra_q      <= '0;
      rb_q      <= '0;
      qa_q      <= '0;
      qb_q      <= '0;
      res_num_q <= '0;
      res_den_q <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            n_q     <= sum;
            d_q     <= RW'(m2);
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (n_q == '0 || d_q == '0) begin
            res_num_q <= n_q;
            res_den_q <= d_q;
            valid_q   <= 1'b1;
            state_q   <= ST_IDLE;
          end else begin
            sn_q    <= n_q[RW-1];
            sd_q    <= d_q[RW-1];
            u_q     <= mag_n;
            v_q     <= mag_d;
            qa_q    <= mag_n;
            qb_q    <= mag_d;
            k_q     <= '0;
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (u_q == '0 || v_q == '0) begin
            g_q     <= (u_q | v_q) << k_q;
            ra_q    <= '0;
            rb_q    <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            u_q <= u_d;
            v_q <= v_d;
            k_q <= k_d;
          end
        end
        ST_DIV: begin
          ra_q  <= ga ? MW'(ta - {1'b0, g_q}) : ta[MW-1:0];
          rb_q  <= gb ? MW'(tb - {1'b0, g_q}) : tb[MW-1:0];
          qa_q  <= {qa_q[MW-2:0], ga};
          qb_q  <= {qb_q[MW-2:0], gb};
          cnt_q <= cnt_q + KW'(1);
          if (cnt_q == KW'(MW - 1)) state_q <= ST_FIN;
        end
        ST_FIN: begin
          res_num_q <= qa_ext;
          res_den_q <= qb_ext;
          valid_q   <= 1'b1;
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign valid_o   = valid_q;
  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_gcd_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GCD) |-> (u_q != '0 || v_q != '0))
    else $error("gcd operands both zero");

  a_div_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> (ra_q == '0 && rb_q == '0))
    else $error("reduction left a remainder");

endmodule

`default_nettype wire

FILE: rtl/core/rational_arith_reduce_top.sv
// channel   direction  handshake            payload
// command   in         start / busy         func_i, a_num_i, a_den_i, b_num_i, b_den_i
// result    out        valid_o (one cycle)  res_num_o, res_den_o
//
// a transaction is taken at a clock edge with start high and busy low
// the back end reads the queue, sets up, runs the binary gcd loop, then the
// divider, and drives the result; it takes no new item from the queue until
// it has finished the last one
// a zero numerator or denominator skips reduction
// reset (rst_ni, async, active low) empties the queue and idles the back end
// the receiver cannot stall; busy is high only while the queue is full

`default_nettype none

module rational_arith_reduce_top
  import rar_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = RAR_OPERAND_WIDTH,
  parameter int unsigned QUEUE_DEPTH   = RAR_QUEUE_DEPTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [1:0]                 func_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]   a_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]   a_den_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]   b_num_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]   b_den_i,
  output logic                                   valid_o,
  output logic signed      [2*OPERAND_WIDTH:0]   res_num_o,
  output logic signed      [2*OPERAND_WIDTH:0]   res_den_o
);

  // queue entry: numerator terms and denominator product
  localparam int unsigned EW = 6 * OPERAND_WIDTH;

  rar_q_stat_t     q_stat;
  logic            push, pop;
  logic [EW-1:0]   push_data, pop_data;

  // front: classify the operation and form the three products
  rar_front #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_front (
    .start      (start),
    .q_stat_i   (q_stat),
    .func_i     (func_i),
    .a_num_i    (a_num_i),
    .a_den_i    (a_den_i),
    .b_num_i    (b_num_i),
    .b_den_i    (b_den_i),
    .push_o     (push),
    .push_data_o(push_data)
  );

  // short queue so the front keeps taking commands while the back reduces
  rar_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .stat_o     (q_stat)
  );

  // back: sum, gcd of magnitudes, exact division of both parts
  rar_back #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .pop_data_i(pop_data),
    .pop_o     (pop),
    .valid_o   (valid_o),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o)
  );

  assign busy = q_stat.full;

endmodule

`default_nettype wire

FILE: bench/rational_arith_reduce_top_test.sv
`default_nettype none

module rational_arith_reduce_top_test;
  import rar_pkg::*;

  localparam int unsigned OPW          = RAR_OPERAND_WIDTH;
  localparam int unsigned RW           = 2 * OPW + 1;
  localparam int unsigned N_RANDOM     = 1200;
  // generous bound: worst-case reductions plus sender gaps, taken many times over
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // longest reduction the back end can need, plus margin
  localparam int unsigned DRAIN_CYCLES = 6 * OPW + 16;

  typedef logic signed [OPW-1:0] operand_t;
  typedef logic signed [RW-1:0]  result_t;

  typedef struct {
    result_t num;
    result_t den;
  } fraction_t;

  localparam operand_t OP_MAX = operand_t'((1 << (OPW - 1)) - 1);
  localparam operand_t OP_MIN = operand_t'(-(1 << (OPW - 1)));

  // expected fractions in issue order; the block answers strictly in order
  class fraction_board;
    int unsigned mismatches;
    fraction_t   expected_q[$];

    // work out the reduced fraction for an accepted transaction and queue it
    function void note_command(rar_func_e f, operand_t an_v, operand_t ad_v,
                               operand_t bn_v, operand_t bd_v);
      longint    an, ad, bn, bd, n, d, x, y, t;
      fraction_t r;
      an = an_v;
      ad = ad_v;
      bn = bn_v;
      bd = bd_v;
      case (f)
        RAR_ADD: begin
          n = an * bd + bn * ad;
          d = ad * bd;
        end
        RAR_MUL: begin
          n = an * bn;
          d = ad * bd;
        end
        RAR_DIV: begin
          n = an * bd;
          d = ad * bn;
        end
        default: begin
          // pass-through of a, still reduced
          n = an;
          d = ad;
        end
      endcase
      // zero on either side: left unreduced
      if (n != 0 && d != 0) begin
        // euclid on the magnitudes, signs stay where they fell
        x = (n < 0) ? -n : n;
        y = (d < 0) ? -d : d;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        if (x > 1) begin
          n = n / x;
          d = d / x;
        end
      end
      r.num = n[RW-1:0];
      r.den = d[RW-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_fraction(result_t num, result_t den);
      fraction_t e;
      if (expected_q.size() == 0) begin
        $error("result %0d/%0d with no transaction outstanding", num, den);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (num !== e.num) begin
        $error("res_num: expected %0d, got %0d", e.num, num);
        mismatches++;
      end
      if (den !== e.den) begin
        $error("res_den: expected %0d, got %0d", e.den, den);
        mismatches++;
      end
    endfunction
  endclass

  // clock and reset; every input known from time zero
  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  logic     [1:0] func_i = RAR_ADD;
  operand_t a_num_i = '0;
  operand_t a_den_i = '0;
  operand_t b_num_i = '0;
  operand_t b_den_i = '0;
  logic     valid_o;
  result_t  res_num_o;
  result_t  res_den_o;

  fraction_board board;
  int unsigned   cycle_count = 0;

  always #1 clk_i = ~clk_i;

  rational_arith_reduce_top i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .func_i    (func_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .valid_o   (valid_o),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o)
  );

  // result side cannot stall: take every strobe at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      board.check_fraction(res_num_o, res_den_o);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one command transaction, optionally preceded by an idle gap
  // inputs move on the falling edge; busy only changes at rising edges,
  // so its value at the falling edge decides the next rising edge
  task automatic send_command(rar_func_e f, operand_t an, operand_t ad,
                              operand_t bn, operand_t bd, bit may_idle);
    int unsigned gap;
    gap = 0;
    if (may_idle && $urandom_range(0, 99) < 21) begin
      // mostly short gaps, now and then a long one so the back end drains
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 120) : $urandom_range(1, 4);
    end
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start   <= 1'b1;
    func_i  <= f;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    board.note_command(f, an, ad, bn, bd);
  endtask

  // random operand; style is shared by all four fields of one transaction
  function automatic operand_t pick_operand(int unsigned style, int unsigned factor);
    case (style)
      0: return operand_t'($urandom);
      1: return operand_t'(int'($urandom_range(0, 40)) - 20);
      2: begin
        case ($urandom_range(0, 5))
          0: return OP_MIN;
          1: return OP_MIN + operand_t'(1);
          2: return operand_t'(-1);
          3: return operand_t'(0);
          4: return operand_t'(1);
          default: return OP_MAX;
        endcase
      end
      // shared factor so that large gcds show up
      default: return operand_t'(int'(factor) * (int'($urandom_range(0, 200)) - 100));
    endcase
  endfunction

  initial begin
    int unsigned style;
    int unsigned factor;
    board = new;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every operation, extremes, zeros and sign placement
    send_command(RAR_ADD,  1, 2, 1, 3, 1'b0);
    send_command(RAR_ADD,  OP_MAX, OP_MIN, OP_MIN, OP_MAX, 1'b0);
    send_command(RAR_ADD,  OP_MIN, OP_MIN, OP_MIN, OP_MIN, 1'b0);
    send_command(RAR_ADD,  OP_MIN, OP_MAX, OP_MIN, OP_MAX, 1'b1);
    send_command(RAR_ADD,  OP_MAX, OP_MAX, OP_MAX, OP_MAX, 1'b0);
    send_command(RAR_ADD,  0, 0, 0, 0, 1'b0);
    send_command(RAR_ADD,  1, 4, -1, 4, 1'b0);
    send_command(RAR_ADD,  3, 0, 5, 7, 1'b1);
    send_command(RAR_MUL,  OP_MIN, OP_MIN, OP_MIN, OP_MIN, 1'b0);
    send_command(RAR_MUL,  OP_MIN, 1, OP_MIN, 1, 1'b0);
    send_command(RAR_MUL,  OP_MAX, OP_MIN, OP_MIN, OP_MAX, 1'b0);
    send_command(RAR_MUL,  -4, 6, 3, 2, 1'b0);
    send_command(RAR_MUL,  7, 9, 11, 13, 1'b1);
    send_command(RAR_MUL,  0, 5, 3, 9, 1'b0);
    send_command(RAR_DIV,  -3, 4, 9, -8, 1'b0);
    send_command(RAR_DIV,  5, 6, 0, 7, 1'b0);
    send_command(RAR_DIV,  OP_MIN, OP_MAX, OP_MAX, OP_MIN, 1'b1);
    send_command(RAR_DIV,  -1, -1, -1, -1, 1'b0);
    send_command(RAR_PASS, 6, -4, 0, 0, 1'b0);
    send_command(RAR_PASS, -6, 4, OP_MAX, OP_MIN, 1'b0);
    send_command(RAR_PASS, 0, 5, 1, 1, 1'b0);
    send_command(RAR_PASS, 7, 0, 2, 3, 1'b1);
    send_command(RAR_PASS, OP_MIN, OP_MIN, -1, -1, 1'b0);

    // random part, with one long stretch of back-to-back commands
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      style  = $urandom_range(0, 99);
      style  = (style < 35) ? 0 : (style < 70) ? 1 : (style < 85) ? 2 : 3;
      factor = $urandom_range(2, 300);
      send_command(rar_func_e'($urandom_range(0, 3)),
                   pick_operand(style, factor), pick_operand(style, factor),
                   pick_operand(style, factor), pick_operand(style, factor),
                   !(i >= 400 && i < 700));
    end
    @(negedge clk_i);
    start <= 1'b0;

    // wait out the last results, then look for strays
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
